[rtl/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// Centroid bounding sphere package
// Shared controller states and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package cbs_pkg;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_LOAD,
      ST_DIV,
      ST_PASS_LOAD,
      ST_PASS,
      ST_SQRT_LOAD,
      ST_SQRT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic div_start;
      logic div_run;
      logic pass_start;
      logic pass_run;
      logic sqrt_start;
      logic sqrt_run;
      logic result_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic pass_done;
      logic sqrt_done;
      logic out_free;
   } status_type;

endpackage

[rtl/cbs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module cbs_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cbs_ctrl.sv]
// ----------------------------------------------------------------------------
// Centroid bounding sphere controller
// Sequences point intake, the centre divide, the distance pass, the square
// root and the hand-over of the result word.
// ----------------------------------------------------------------------------
module cbs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last_point,
   output logic               req_stall,
   input  cbs_pkg::status_type status,
   output cbs_pkg::cmd_type    cmd
);
   import cbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last_point) state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD:  state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) state_in = ST_PASS_LOAD;
         end
         ST_PASS_LOAD: state_in = ST_PASS;
         ST_PASS: begin
            if (status.pass_done) state_in = ST_SQRT_LOAD;
         end
         ST_SQRT_LOAD: state_in = ST_SQRT;
         ST_SQRT: begin
            if (status.sqrt_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         ST_DIV_LOAD:  cmd.div_start = 1'b1;
         ST_DIV:       cmd.div_run = !status.div_done;
         ST_PASS_LOAD: cmd.pass_start = 1'b1;
         ST_PASS:      cmd.pass_run = 1'b1;
         ST_SQRT_LOAD: cmd.sqrt_start = 1'b1;
         ST_SQRT:      cmd.sqrt_run = !status.sqrt_done;
         ST_FINISH:    cmd.result_load = status.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

[rtl/cbs_datapath.sv]
// ----------------------------------------------------------------------------
// Centroid bounding sphere datapath
// Point store, running sums, serial divider, distance pipeline, serial
// square root and the result register.
// ----------------------------------------------------------------------------
module cbs_datapath #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cbs_pkg::cmd_type              cmd,
   output cbs_pkg::status_type           status,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]  rsp_center_x,
   output logic signed [COORD_BITS-1:0]  rsp_center_y,
   output logic signed [COORD_BITS-1:0]  rsp_center_z,
   output logic        [COORD_BITS:0]    rsp_radius,
   output logic                          rsp_overflowed
);
   import cbs_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int AW  = $clog2(MAX_POINTS);
   localparam int SW  = CB + CW;
   localparam int DCW = $clog2(SW + 1);
   localparam int SQW = 2 * CB + 2;
   localparam int QW  = (SQW > 64) ? 64 : SQW;
   localparam int RW  = QW / 2;
   localparam int RCW = $clog2(RW + 1);

   // Intake: count, sums and drop flag.
   logic [CW-1:0]        count_ff;
   logic signed [SW-1:0] sum_ff [3];
   logic                 drop_ff;
   logic [CB-1:0]        pin [3];
   logic                 room;

   assign pin[0] = req_point_x;
   assign pin[1] = req_point_y;
   assign pin[2] = req_point_z;
   assign room   = count_ff < CW'(MAX_POINTS);

   always_ff @(posedge clock) begin
      if (reset || cmd.result_load) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         for (int a = 0; a < 3; a++) sum_ff[a] <= '0;
      end else if (cmd.take) begin
         if (room) begin
            count_ff <= count_ff + 1'b1;
            for (int a = 0; a < 3; a++) begin
               sum_ff[a] <= sum_ff[a] + {{(SW-CB){pin[a][CB-1]}}, pin[a]};
            end
         end else begin
            drop_ff <= 1'b1;
         end
      end
   end

   // Point store.
   logic [AW-1:0]   rd_addr;
   logic            rd_en;
   logic [3*CB-1:0] rd_data;

   cbs_ram #(.WIDTH(3 * CB), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (cmd.take && room),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({pin[2], pin[1], pin[0]}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Serial restoring divider, one quotient bit per cycle on all three axes.
   logic [SW-1:0]  quo_ff [3];
   logic [CW-1:0]  rem_ff [3];
   logic [DCW-1:0] div_cnt_ff;
   logic [CW:0]    rem_try [3];
   logic [CB-1:0]  cen_calc [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rem_try[a]  = {rem_ff[a], quo_ff[a][SW-1]};
         cen_calc[a] = sum_ff[a][SW-1] ? CB'(-quo_ff[a]) : CB'(quo_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= DCW'(SW);
      end else if (cmd.div_run) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (cmd.div_start) begin
            rem_ff[a] <= '0;
            quo_ff[a] <= sum_ff[a][SW-1] ? -sum_ff[a] : sum_ff[a];
         end else if (cmd.div_run) begin
            if (rem_try[a] >= {1'b0, count_ff}) begin
               rem_ff[a] <= CW'(rem_try[a] - {1'b0, count_ff});
               quo_ff[a] <= {quo_ff[a][SW-2:0], 1'b1};
            end else begin
               rem_ff[a] <= rem_try[a][CW-1:0];
               quo_ff[a] <= {quo_ff[a][SW-2:0], 1'b0};
            end
         end
      end
   end

   // Distance pass: read, difference, square, sum, maximum.
   logic [CB-1:0] cen_ff [3];
   logic [CW-1:0] addr_ff;
   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic [CB-1:0] mag_ff [3];
   logic [CB-1:0] mag_in [3];
   logic [2*CB-1:0] sq_ff [3];
   logic [QW-1:0] dist_ff;
   logic [QW-1:0] dist_in;
   logic [SQW-1:0] dist_wide;
   logic [QW-1:0] max_ff;

   assign rd_en   = cmd.pass_run && (addr_ff != count_ff);
   assign rd_addr = addr_ff[AW-1:0];

   always_comb begin
      logic signed [CB:0] d;
      for (int a = 0; a < 3; a++) begin
         d = $signed({rd_data[a*CB+CB-1], rd_data[a*CB +: CB]})
           - $signed({cen_ff[a][CB-1], cen_ff[a]});
         mag_in[a] = d[CB] ? CB'(-d) : d[CB-1:0];
      end
      dist_wide = SQW'(sq_ff[0]) + SQW'(sq_ff[1]) + SQW'(sq_ff[2]);
      if ((dist_wide >> QW) != '0) begin
         dist_in = '1;
      end else begin
         dist_in = dist_wide[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.pass_start) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pass_start) begin
         addr_ff <= '0;
         max_ff  <= '0;
         for (int a = 0; a < 3; a++) cen_ff[a] <= cen_calc[a];
      end else begin
         if (rd_en) addr_ff <= addr_ff + 1'b1;
         if (v4_ff && (dist_ff > max_ff)) max_ff <= dist_ff;
      end
      for (int a = 0; a < 3; a++) begin
         mag_ff[a] <= mag_in[a];
         sq_ff[a]  <= mag_ff[a] * mag_ff[a];
      end
      dist_ff <= dist_in;
   end

   // Serial square root, one root bit per cycle.
   logic [QW-1:0]  val_ff;
   logic [RW+1:0]  srem_ff;
   logic [RW-1:0]  root_ff;
   logic [RCW-1:0] sq_cnt_ff;
   logic [RW+1:0]  srem_sh;
   logic [RW+1:0]  trial;

   assign srem_sh = {srem_ff[RW-1:0], val_ff[QW-1:QW-2]};
   assign trial   = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_cnt_ff <= '0;
      end else if (cmd.sqrt_start) begin
         sq_cnt_ff <= RCW'(RW);
      end else if (cmd.sqrt_run) begin
         sq_cnt_ff <= sq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         val_ff  <= max_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_run) begin
         val_ff <= {val_ff[QW-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_ff <= srem_sh - trial;
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   // Result word register.
   logic rsp_valid_ff;
   logic [CB-1:0] out_cen_ff [3];
   logic [CB:0]   out_rad_ff;
   logic          out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         for (int a = 0; a < 3; a++) out_cen_ff[a] <= cen_ff[a];
         out_rad_ff <= (CB+1)'(root_ff);
         out_ovf_ff <= drop_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_center_x   = out_cen_ff[0];
   assign rsp_center_y   = out_cen_ff[1];
   assign rsp_center_z   = out_cen_ff[2];
   assign rsp_radius     = out_rad_ff;
   assign rsp_overflowed = out_ovf_ff;

   // Status back to the controller.
   assign status.div_done  = (div_cnt_ff == '0);
   assign status.pass_done = (addr_ff == count_ff) && !v1_ff && !v2_ff && !v3_ff && !v4_ff;
   assign status.sqrt_done = (sq_cnt_ff == '0);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

[rtl/centroid_bounding_sphere_unit.sv]
// ----------------------------------------------------------------------------
// Centroid bounding sphere unit
// Collects a set of 3D points and returns its centroid and enclosing radius.
// ----------------------------------------------------------------------------
// The req_ channel carries one point per word, with req_last_point closing a
// set. Points are taken one per cycle while the unit is collecting; a point
// beyond MAX_POINTS is dropped and reported in rsp_overflowed.
// On the closing point the unit stalls req_ and works through the set: a
// serial divide of COORD_BITS+clog2(MAX_POINTS+1) quotient bits, a pass over
// the point store (one memory read a cycle into a five-stage distance
// pipeline) and a serial square root of COORD_BITS+1 root bits (32 at most),
// each behind a load state of the controller, which then waits in its finish
// state; req_stall stays high until the result word is loaded.
// The result word then sits in an output register; the unit returns to
// intake at once unless an earlier word is still held there under
// rsp_stall, in which case it waits for that word to leave.
// Reset is synchronous and clears the controller, counts, sums and the
// result valid; the point store needs no clearing.
// ----------------------------------------------------------------------------
module centroid_bounding_sphere_unit #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,
   input  logic                          req_last_point,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]  rsp_center_x,
   output logic signed [COORD_BITS-1:0]  rsp_center_y,
   output logic signed [COORD_BITS-1:0]  rsp_center_z,
   output logic        [COORD_BITS:0]    rsp_radius,
   output logic                          rsp_overflowed
);
   import cbs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   cbs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   // Arithmetic and storage.
   cbs_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_center_x   (rsp_center_x),
      .rsp_center_y   (rsp_center_y),
      .rsp_center_z   (rsp_center_z),
      .rsp_radius     (rsp_radius),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule
